// File: sv/cpr_pkg.sv
// cpr_pkg: shared sizes, types and register codes for the clock page replacement block.
// No dependencies; used by every module of the block.
package cpr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int ADDR_W    = 3;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [15:0]          port_page_t;
  typedef logic [2:0]           frame_idx_t;
  typedef logic [3:0]           cfg_t;

  // register index taken from paddr[2]
  localparam logic REG_FRAMES_IN_USE = 1'b0;
  localparam cfg_t FRAMES_RST        = 4'd8;

  typedef struct packed {
    idx_t  idx;
    logic  set_ref;
    logic  clr_ref;
    logic  load;
    page_t wr_page;
  } frm_req_t;

  typedef struct packed {
    page_t page;
    logic  valid;
    logic  ref_set;
  } frm_rsp_t;

endpackage

// File: sv/cpr_frames.sv
// cpr_frames: frame store holding page numbers, valid bits and reference bits.
// Depends on cpr_pkg; one indexed read and write port driven by the sequencer.
module cpr_frames (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpr_pkg::frm_req_t req_i,
  output cpr_pkg::frm_rsp_t rsp_o
);

  cpr_pkg::page_t              page_q [cpr_pkg::FRAMES];
  logic [cpr_pkg::FRAMES-1:0]  valid_q, valid_d;
  logic [cpr_pkg::FRAMES-1:0]  ref_q, ref_d;

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      page_q[req_i.idx] <= req_i.wr_page;
    end
  end

  always_comb begin
    valid_d = valid_q;
    ref_d   = ref_q;
    if (req_i.load) begin
      valid_d[req_i.idx] = 1'b1;
      ref_d[req_i.idx]   = 1'b1;
    end else if (req_i.set_ref) begin
      ref_d[req_i.idx] = 1'b1;
    end else if (req_i.clr_ref) begin
      ref_d[req_i.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ref_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ref_q   <= ref_d;
    end
  end

  assign rsp_o.page    = page_q[req_i.idx];
  assign rsp_o.valid   = valid_q[req_i.idx];
  assign rsp_o.ref_set = ref_q[req_i.idx];

endmodule

// File: sv/cpr_seq.sv
// cpr_seq: sequencer for lookup and hand sweep, one frame per cycle, plus result register.
// Depends on cpr_pkg; drives cpr_frames through frm_req_t.
module cpr_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       page_id_i,
  input  cpr_pkg::cfg_t     frames_in_use_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [2:0]        frame_index_o,
  output logic              victim_valid_o,
  output logic [15:0]       victim_page_o,
  output logic [31:0]       fault_count_o,
  output cpr_pkg::frm_req_t frm_req_o,
  input  cpr_pkg::frm_rsp_t frm_rsp_i
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  cpr_pkg::idx_t       idx_q, idx_d;
  cpr_pkg::idx_t       hand_q, hand_d;
  cpr_pkg::cnt_t       n_q, n_d;
  cpr_pkg::page_t      page_q, page_d;
  logic [31:0]         faults_q, faults_d;
  logic                hit_q, hit_d;
  logic                vvalid_q, vvalid_d;
  cpr_pkg::page_t      vpage_q, vpage_d;

  logic                out_valid_q, out_valid_d;
  logic                out_hit_q;
  cpr_pkg::frame_idx_t out_idx_q;
  logic                out_vvalid_q;
  cpr_pkg::port_page_t out_vpage_q;
  logic [31:0]         out_faults_q;

  logic                accept;
  logic                load_out;
  logic                last;
  cpr_pkg::idx_t       idx_next;
  cpr_pkg::cnt_t       n_cfg;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // idx + 1 with wrap at the active frame count
  assign last     = (cpr_pkg::cnt_t'(idx_q) + cpr_pkg::cnt_t'(1)) >= n_q;
  assign idx_next = last ? '0 : cpr_pkg::idx_t'(idx_q + cpr_pkg::idx_t'(1));

  always_comb begin
    if (frames_in_use_i == '0) begin
      n_cfg = cpr_pkg::cnt_t'(1);
    end else if (32'(frames_in_use_i) > 32'(cpr_pkg::FRAMES)) begin
      n_cfg = cpr_pkg::cnt_t'(cpr_pkg::FRAMES);
    end else begin
      n_cfg = cpr_pkg::cnt_t'(frames_in_use_i);
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    hand_d    = hand_q;
    n_d       = n_q;
    page_d    = page_q;
    faults_d  = faults_q;
    hit_d     = hit_q;
    vvalid_d  = vvalid_q;
    vpage_d   = vpage_q;
    frm_req_o = '{idx: idx_q, set_ref: 1'b0, clr_ref: 1'b0, load: 1'b0, wr_page: page_q};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          page_d  = cpr_pkg::page_t'(page_id_i);
          n_d     = n_cfg;
          idx_d   = '0;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (frm_rsp_i.valid && (frm_rsp_i.page == page_q)) begin
          frm_req_o.set_ref = 1'b1;
          hit_d    = 1'b1;
          vvalid_d = 1'b0;
          vpage_d  = '0;
          state_d  = S_DONE;
        end else if (last) begin
          hit_d    = 1'b0;
          faults_d = (faults_q == '1) ? faults_q : faults_q + 32'd1;
          idx_d    = (cpr_pkg::cnt_t'(hand_q) < n_q) ? hand_q : '0;
          state_d  = S_SWEEP;
        end else begin
          idx_d = idx_next;
        end
      end
      S_SWEEP: begin
        if (!frm_rsp_i.ref_set) begin
          frm_req_o.load = 1'b1;
          vvalid_d = frm_rsp_i.valid;
          vpage_d  = frm_rsp_i.valid ? frm_rsp_i.page : '0;
          hand_d   = idx_next;
          state_d  = S_DONE;
        end else begin
          frm_req_o.clr_ref = 1'b1;
          idx_d = idx_next;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hand_q      <= '0;
      faults_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hand_q      <= hand_d;
      faults_q    <= faults_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    n_q      <= n_d;
    page_q   <= page_d;
    hit_q    <= hit_d;
    vvalid_q <= vvalid_d;
    vpage_q  <= vpage_d;
    if (load_out) begin
      out_hit_q    <= hit_q;
      out_idx_q    <= cpr_pkg::frame_idx_t'(idx_q);
      out_vvalid_q <= vvalid_q;
      out_vpage_q  <= cpr_pkg::port_page_t'(vpage_q);
      out_faults_q <= faults_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign frame_index_o  = out_idx_q;
  assign victim_valid_o = out_vvalid_q;
  assign victim_page_o  = out_vpage_q;
  assign fault_count_o  = out_faults_q;

endmodule

// File: sv/clock_page_replacement_top.sv
// clock_page_replacement_top: clock (second-chance) page replacement with APB config port.
// Operation: a lookup scans active frames from frame 0; a hit sets that frame's ref bit;
// a fault sweeps from the hand, clearing reference bits, and fills the first clear frame.
// Throughput: one transaction in flight; the next is taken once the result is registered.
// Reset: all frames empty, reference bits clear, hand 0, fault count 0, frames_in_use 8.
// Depends on cpr_pkg, cpr_frames and cpr_seq.
module clock_page_replacement_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cpr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [15:0]                page_id_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       hit_o,
  output logic [2:0]                 frame_index_o,
  output logic                       victim_valid_o,
  output logic [15:0]                victim_page_o,
  output logic [31:0]                fault_count_o
);

  cpr_pkg::cfg_t     frames_in_use_q, frames_in_use_d;
  cpr_pkg::frm_req_t frm_req;
  cpr_pkg::frm_rsp_t frm_rsp;
  logic              sel_reg;

  assign pready  = 1'b1;
  assign sel_reg = (paddr[2] == cpr_pkg::REG_FRAMES_IN_USE);

  always_comb begin
    frames_in_use_d = frames_in_use_q;
    if (psel && penable && pwrite && sel_reg) begin
      frames_in_use_d = cpr_pkg::cfg_t'(pwdata[3:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= cpr_pkg::FRAMES_RST;
    end else begin
      frames_in_use_q <= frames_in_use_d;
    end
  end

  assign prdata = sel_reg ? {28'd0, frames_in_use_q} : 32'd0;

  cpr_frames u_frames (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (frm_req),
    .rsp_o  (frm_rsp)
  );

  cpr_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .page_id_i       (page_id_i),
    .frames_in_use_i (frames_in_use_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .victim_valid_o  (victim_valid_o),
    .victim_page_o   (victim_page_o),
    .fault_count_o   (fault_count_o),
    .frm_req_o       (frm_req),
    .frm_rsp_i       (frm_rsp)
  );

endmodule
